@@ src/cld_pkg.sv @@
package cld_pkg;

   localparam int PrefixLen = 16;
   localparam int PrefixIdxW = 4;
   localparam int OutLenW = 32;

   localparam logic [7:0] CharCr = 8'h0d;
   localparam logic [7:0] CharLf = 8'h0a;
   localparam logic [7:0] CharBigC = 8'h43;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   typedef struct packed {
      logic                vld;
      logic [7:0]          body_byte;
      logic                body_last;
      logic [OutLenW-1:0]  body_length;
      logic                empty_body;
      logic                header_error;
   } result_type;

   // "Content-Length: "
   function automatic logic [7:0] prefix_char(input logic [PrefixIdxW-1:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h43;
         4'd1:    ch = 8'h6f;
         4'd2:    ch = 8'h6e;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6e;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2d;
         4'd8:    ch = 8'h4c;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6e;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         4'd14:   ch = 8'h3a;
         4'd15:   ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ src/cld_in_stage.sv @@
module cld_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       advance,
   output logic       in_vld,
   output logic [7:0] in_byte
);

   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       fire;

   assign req_ready = !vld_ff || advance;
   assign fire = req_valid && req_ready;

   always_comb begin
      vld_in = vld_ff;
      byte_in = byte_ff;
      if (fire) begin
         vld_in = 1'b1;
         byte_in = req_in_byte;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      byte_ff <= byte_in;
   end

   assign in_vld = vld_ff;
   assign in_byte = byte_ff;

endmodule

@@ src/cld_parser.sv @@
module cld_parser #(
   parameter int LEN_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   output cld_pkg::result_type res
);

   localparam int AccW = LEN_BITS + 4;

   typedef enum logic [2:0] {
      PH_SEEK,
      PH_DIGITS,
      PH_HEADER,
      PH_BODY,
      PH_ERROR
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [cld_pkg::PrefixIdxW-1:0]   pfx_ff, pfx_in;
   logic [LEN_BITS-1:0]              acc_ff, acc_in;
   logic                             seen_ff, seen_in;
   logic [1:0]                       term_ff, term_in;
   logic [LEN_BITS-1:0]              rem_ff, rem_in;

   logic          is_cr, is_lf, is_digit;
   logic [3:0]    digit;
   logic [AccW-1:0] acc_ext, acc_next;
   logic          ovf;

   assign is_cr = (in_byte == cld_pkg::CharCr);
   assign is_lf = (in_byte == cld_pkg::CharLf);
   assign is_digit = (in_byte >= cld_pkg::CharZero) && (in_byte <= cld_pkg::CharNine);
   assign digit = 4'(in_byte - cld_pkg::CharZero);
   assign acc_ext = AccW'(acc_ff);
   // acc * 10 + digit; any bit above LEN_BITS means overflow
   assign acc_next = (acc_ext << 3) + (acc_ext << 1) + AccW'(digit);
   assign ovf = |acc_next[AccW-1:LEN_BITS];

   always_comb begin
      phase_in = phase_ff;
      pfx_in = pfx_ff;
      acc_in = acc_ff;
      seen_in = seen_ff;
      term_in = term_ff;
      rem_in = rem_ff;
      res = '0;
      case (phase_ff)
         PH_SEEK: begin
            if (in_byte == cld_pkg::prefix_char(pfx_ff)) begin
               if (pfx_ff == cld_pkg::PrefixIdxW'(cld_pkg::PrefixLen - 1)) begin
                  pfx_in = '0;
                  phase_in = PH_DIGITS;
                  acc_in = '0;
                  seen_in = 1'b0;
                  term_in = '0;
               end else begin
                  pfx_in = pfx_ff + cld_pkg::PrefixIdxW'(1);
               end
            end else begin
               pfx_in = (in_byte == cld_pkg::CharBigC) ? cld_pkg::PrefixIdxW'(1) : '0;
            end
         end
         PH_DIGITS: begin
            if (term_ff == 2'd1) begin
               if (is_lf) begin
                  phase_in = PH_HEADER;
                  term_in = 2'd2;
               end else begin
                  phase_in = PH_ERROR;
                  res.vld = 1'b1;
                  res.header_error = 1'b1;
               end
            end else if (is_cr) begin
               if (seen_ff) begin
                  term_in = 2'd1;
               end else begin
                  phase_in = PH_ERROR;
                  res.vld = 1'b1;
                  res.header_error = 1'b1;
               end
            end else if (is_digit && !ovf) begin
               acc_in = acc_next[LEN_BITS-1:0];
               seen_in = 1'b1;
            end else begin
               phase_in = PH_ERROR;
               res.vld = 1'b1;
               res.header_error = 1'b1;
            end
         end
         PH_HEADER: begin
            if ((term_ff == 2'd0 || term_ff == 2'd2) && is_cr) begin
               term_in = term_ff + 2'd1;
            end else if (term_ff == 2'd1 && is_lf) begin
               term_in = 2'd2;
            end else if (term_ff == 2'd3 && is_lf) begin
               term_in = '0;
               if (acc_ff == '0) begin
                  phase_in = PH_SEEK;
                  res.vld = 1'b1;
                  res.body_last = 1'b1;
                  res.empty_body = 1'b1;
               end else begin
                  rem_in = acc_ff;
                  phase_in = PH_BODY;
               end
            end else begin
               term_in = is_cr ? 2'd1 : 2'd0;
            end
         end
         PH_BODY: begin
            rem_in = rem_ff - LEN_BITS'(1);
            res.vld = 1'b1;
            res.body_byte = in_byte;
            res.body_length = cld_pkg::OutLenW'(acc_ff);
            if (rem_ff == LEN_BITS'(1)) begin
               phase_in = PH_SEEK;
               pfx_in = '0;
               res.body_last = 1'b1;
            end
         end
         PH_ERROR: begin
            // stopped until reset
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         pfx_ff <= '0;
         acc_ff <= '0;
         seen_ff <= 1'b0;
         term_ff <= '0;
         rem_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pfx_ff <= pfx_in;
         acc_ff <= acc_in;
         seen_ff <= seen_in;
         term_ff <= term_in;
         rem_ff <= rem_in;
      end
   end

endmodule

@@ src/cld_out_stage.sv @@
module cld_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cld_pkg::result_type          res,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_body_byte,
   output logic                         rsp_body_last,
   output logic [cld_pkg::OutLenW-1:0]  rsp_body_length,
   output logic                         rsp_empty_body,
   output logic                         rsp_header_error
);

   logic                vld_ff, vld_in;
   cld_pkg::result_type data_ff, data_in;

   always_comb begin
      vld_in = vld_ff && !rsp_ready;
      data_in = data_ff;
      if (advance) begin
         vld_in = res.vld;
         if (res.vld) begin
            data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_body_byte = data_ff.body_byte;
   assign rsp_body_last = data_ff.body_last;
   assign rsp_body_length = data_ff.body_length;
   assign rsp_empty_body = data_ff.empty_body;
   assign rsp_header_error = data_ff.header_error;

endmodule

@@ src/content_length_deframer_unit.sv @@
// channel  | direction | handshake              | payload
// req_     | in        | req_valid / req_ready  | req_in_byte[7:0]
// rsp_     | out       | rsp_valid / rsp_ready  | rsp_body_byte, rsp_body_last,
//          |           |                        | rsp_body_length[31:0], rsp_empty_body,
//          |           |                        | rsp_header_error
//
// One byte per cycle while the result register drains or has room.
// Each byte sits in the input register, then the header state machine decides
// combinationally whether it yields a word for the result register.
// A stalled result register holds the input register; req_ready stays high as
// long as the result register drains or has room.
// Synchronous reset returns to prefix search; after a header error every
// byte is consumed with no result until reset.
module content_length_deframer_unit #(
   parameter int LEN_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_body_byte,
   output logic                         rsp_body_last,
   output logic [cld_pkg::OutLenW-1:0]  rsp_body_length,
   output logic                         rsp_empty_body,
   output logic                         rsp_header_error
);

   logic                in_vld;
   logic [7:0]          in_byte;
   logic                advance;
   cld_pkg::result_type res;

   // advance the held byte when the result register can take a word
   assign advance = in_vld && (!rsp_valid || rsp_ready);

   cld_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .in_vld      (in_vld),
      .in_byte     (in_byte)
   );

   cld_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte),
      .res     (res)
   );

   cld_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .res              (res),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_body_last    (rsp_body_last),
      .rsp_body_length  (rsp_body_length),
      .rsp_empty_body   (rsp_empty_body),
      .rsp_header_error (rsp_header_error)
   );

endmodule

@@ src/cld_checker.sv @@
module cld_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_in_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_body_byte,
   input logic        rsp_body_last,
   input logic [31:0] rsp_body_length,
   input logic        rsp_empty_body,
   input logic        rsp_header_error
);

   // error word carries nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_error |->
         !rsp_body_last && !rsp_empty_body && rsp_body_byte == 8'd0 &&
         rsp_body_length == 32'd0)
      else $error("error word carries payload");

   // empty body is a single last word with zero length
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_body |->
         rsp_body_last && !rsp_header_error && rsp_body_byte == 8'd0 &&
         rsp_body_length == 32'd0)
      else $error("malformed empty-body word");

   // rsp_valid falls once an error word has been taken
   a_stop_after_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_header_error |=> !rsp_valid)
      else $error("word after header error");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_body_byte) && $stable(rsp_body_length) &&
         $stable(rsp_body_last))
      else $error("stalled result changed");

   // sender keeps a refused word steady
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte))
      else $error("refused request changed");

endmodule

bind content_length_deframer_unit cld_checker u_cld_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_in_byte      (req_in_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_body_byte    (rsp_body_byte),
   .rsp_body_last    (rsp_body_last),
   .rsp_body_length  (rsp_body_length),
   .rsp_empty_body   (rsp_empty_body),
   .rsp_header_error (rsp_header_error)
);
